/* rtl/mfpt_pkg.sv */
package mfpt_pkg;

    localparam int PIXEL_WIDTH   = 128;
    localparam int PAGE_COUNT    = 8;
    localparam int ROW_BYTES     = 16;
    localparam int ROWS_PER_PAGE = 8;
    localparam int MEM_BYTES     = ROW_BYTES * ROWS_PER_PAGE * PAGE_COUNT;
    localparam int BANK_DEPTH    = ROW_BYTES * PAGE_COUNT;
    localparam int BANK_AW       = $clog2(BANK_DEPTH);
    localparam int BANK_SEL_W    = $clog2(ROWS_PER_PAGE);

    localparam int KIND_W     = 3;
    localparam int ADDR_W     = 10;
    localparam int PAGE_W     = 3;
    localparam int COL_W      = 7;
    localparam int BYTE_W     = 8;
    localparam int CAP_PAGE_W = 4;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_ROW_WR   = 3'd0,
        KIND_ROW_RD   = 3'd1,
        KIND_SEL_PAGE = 3'd2,
        KIND_CAP_WR   = 3'd3,
        KIND_COL_RD   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_READ   = 2'd2,
        ST_MODIFY = 2'd3
    } t_state;

    // row r of the image lives in bank r mod 8
    function automatic logic [BANK_SEL_W-1:0] row_bank(input logic [ADDR_W-1:0] addr);
        return BANK_SEL_W'((int'(addr) / ROW_BYTES) % ROWS_PER_PAGE);
    endfunction

    function automatic logic [BANK_AW-1:0] row_word(input logic [ADDR_W-1:0] addr);
        return BANK_AW'((int'(addr) / (ROW_BYTES * ROWS_PER_PAGE)) * ROW_BYTES
                        + int'(addr) % ROW_BYTES);
    endfunction

    function automatic logic [BANK_AW-1:0] col_word(input logic [CAP_PAGE_W-1:0] page,
                                                    input logic [COL_W-1:0] col);
        return BANK_AW'(int'(page) * ROW_BYTES + int'(col >> 3));
    endfunction

    function automatic logic [BYTE_W-1:0] col_mask(input logic [COL_W-1:0] col);
        return BYTE_W'(8'h80 >> col[2:0]);
    endfunction

    function automatic logic col_ok(input logic [CAP_PAGE_W-1:0] page,
                                    input logic [COL_W-1:0] col);
        return (int'(page) < PAGE_COUNT) && (int'(col) < PIXEL_WIDTH)
               && (int'(col >> 3) < ROW_BYTES);
    endfunction

endpackage

/* rtl/mfpt_ram.sv */
module mfpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/monochrome_frame_page_transposer.sv */
// Framebuffer of 128x64 one-bit pixels, row-major bytes with the leftmost pixel in bit 7,
// kept in eight row banks of 128 bytes so that one page-column byte is a single access.
// After reset all 128 words of the banks are swept to zero with tready low. Row writes,
// select-page, unused kinds and capture writes beyond the image finish when accepted; row
// reads and column reads go through a bank read, then the output register; other capture
// writes read and then write back all eight banks at one word. Results leave through an
// output register, so input transfers continue while a result waits, up to the next read,
// which then holds tready low until the output register frees.
module monochrome_frame_page_transposer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // row_address, page_number, column_index, data_byte
    input  logic [mfpt_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic [mfpt_pkg::KIND_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // read_byte
    output logic [mfpt_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // read_view
    output logic                            o_m_axis_tuser
);

    localparam int NB = mfpt_pkg::ROWS_PER_PAGE;
    localparam int AW = mfpt_pkg::BANK_AW;
    localparam int BW = mfpt_pkg::BYTE_W;

    mfpt_pkg::t_state r_state, n_state;
    mfpt_pkg::t_kind  w_kind;

    logic [mfpt_pkg::ADDR_W-1:0]     w_addr;
    logic [mfpt_pkg::PAGE_W-1:0]     w_page;
    logic [mfpt_pkg::COL_W-1:0]      w_col;
    logic [BW-1:0]                   w_data;
    logic                            w_accept;

    logic [AW-1:0]                   r_clr_addr;
    logic [mfpt_pkg::CAP_PAGE_W-1:0] r_cap_page, n_cap_page;
    logic [mfpt_pkg::COL_W-1:0]      r_cap_col, n_cap_col;
    logic                            r_view, r_zero;
    logic [mfpt_pkg::BANK_SEL_W-1:0] r_bank;
    logic [BW-1:0]                   r_mask, r_cap_data;
    logic [AW-1:0]                   r_word;
    logic                            r_out_valid;
    logic [BW-1:0]                   r_out_byte;
    logic                            r_out_view;

    logic [NB-1:0]                   w_we;
    logic [AW-1:0]                   w_waddr;
    logic [BW-1:0]                   w_wdata [NB];
    logic                            w_re;
    logic [AW-1:0]                   w_raddr;
    logic [BW-1:0]                   w_rdata [NB];
    logic [BW-1:0]                   w_result;
    logic                            w_out_free;
    logic                            w_load_out;

    assign w_kind = mfpt_pkg::t_kind'(i_s_axis_tuser);
    assign w_addr = i_s_axis_tdata[9:0];
    assign w_page = i_s_axis_tdata[12:10];
    assign w_col  = i_s_axis_tdata[19:13];
    assign w_data = i_s_axis_tdata[27:20];

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_load_out = (r_state == mfpt_pkg::ST_READ) && w_out_free;

    for (genvar k = 0; k < NB; k++) begin : g_bank
        mfpt_ram #(
            .WIDTH(BW),
            .DEPTH(mfpt_pkg::BANK_DEPTH)
        ) u_bank (
            .i_clk  (i_clk),
            .i_we   (w_we[k]),
            .i_waddr(w_waddr),
            .i_wdata(w_wdata[k]),
            .i_re   (w_re),
            .i_raddr(w_raddr),
            .o_rdata(w_rdata[k])
        );
    end

    always_comb begin
        w_result = '0;
        if (!r_zero) begin
            if (r_view) begin
                for (int k = 0; k < NB; k++) begin
                    w_result[k] = |(w_rdata[k] & r_mask);
                end
            end else begin
                w_result = w_rdata[r_bank];
            end
        end
    end

    always_comb begin
        n_state         = r_state;
        n_cap_page      = r_cap_page;
        n_cap_col       = r_cap_col;
        o_s_axis_tready = (r_state == mfpt_pkg::ST_IDLE);
        w_we            = '0;
        w_waddr         = r_word;
        w_re            = 1'b0;
        w_raddr         = mfpt_pkg::col_word({1'b0, w_page}, w_col);
        for (int k = 0; k < NB; k++) begin
            w_wdata[k] = r_cap_data[k] ? (w_rdata[k] | r_mask) : (w_rdata[k] & ~r_mask);
        end
        case (r_state)
            mfpt_pkg::ST_CLEAR: begin
                w_we    = '1;
                w_waddr = r_clr_addr;
                for (int k = 0; k < NB; k++) begin
                    w_wdata[k] = '0;
                end
                if (r_clr_addr == AW'(mfpt_pkg::BANK_DEPTH - 1)) begin
                    n_state = mfpt_pkg::ST_IDLE;
                end
            end
            mfpt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (w_kind)
                        mfpt_pkg::KIND_ROW_WR: begin
                            w_waddr = mfpt_pkg::row_word(w_addr);
                            for (int k = 0; k < NB; k++) begin
                                w_wdata[k] = w_data;
                            end
                            if (int'(w_addr) < mfpt_pkg::MEM_BYTES) begin
                                w_we[mfpt_pkg::row_bank(w_addr)] = 1'b1;
                            end
                        end
                        mfpt_pkg::KIND_ROW_RD: begin
                            w_re    = 1'b1;
                            w_raddr = mfpt_pkg::row_word(w_addr);
                            n_state = mfpt_pkg::ST_READ;
                        end
                        mfpt_pkg::KIND_SEL_PAGE: begin
                            n_cap_page = {1'b0, w_page};
                            n_cap_col  = '0;
                        end
                        mfpt_pkg::KIND_CAP_WR: begin
                            if (mfpt_pkg::col_ok(r_cap_page, r_cap_col)) begin
                                w_re    = 1'b1;
                                w_raddr = mfpt_pkg::col_word(r_cap_page, r_cap_col);
                                n_state = mfpt_pkg::ST_MODIFY;
                                if (r_cap_col == mfpt_pkg::COL_W'(mfpt_pkg::PIXEL_WIDTH - 1)) begin
                                    n_cap_col  = '0;
                                    n_cap_page = r_cap_page + 1'b1;
                                end else begin
                                    n_cap_col = r_cap_col + 1'b1;
                                end
                            end
                        end
                        mfpt_pkg::KIND_COL_RD: begin
                            w_re    = 1'b1;
                            n_state = mfpt_pkg::ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mfpt_pkg::ST_READ: begin
                if (w_out_free) begin
                    n_state = mfpt_pkg::ST_IDLE;
                end
            end
            mfpt_pkg::ST_MODIFY: begin
                w_we    = '1;
                n_state = mfpt_pkg::ST_IDLE;
            end
            default: begin
                n_state = mfpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mfpt_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_cap_page  <= '0;
            r_cap_col   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cap_page <= n_cap_page;
            r_cap_col  <= n_cap_col;
            if (r_state == mfpt_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // operation context captured with the transfer
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_view     <= (w_kind == mfpt_pkg::KIND_COL_RD) || (w_kind == mfpt_pkg::KIND_CAP_WR);
            r_bank     <= mfpt_pkg::row_bank(w_addr);
            r_cap_data <= w_data;
            r_word     <= mfpt_pkg::col_word(r_cap_page, r_cap_col);
            if (w_kind == mfpt_pkg::KIND_COL_RD) begin
                r_mask <= mfpt_pkg::col_mask(w_col);
                r_zero <= !mfpt_pkg::col_ok({1'b0, w_page}, w_col);
            end else if (w_kind == mfpt_pkg::KIND_CAP_WR) begin
                r_mask <= mfpt_pkg::col_mask(r_cap_col);
                r_zero <= 1'b0;
            end else begin
                r_mask <= '0;
                r_zero <= !(int'(w_addr) < mfpt_pkg::MEM_BYTES);
            end
        end
        if (w_load_out) begin
            r_out_byte <= w_result;
            r_out_view <= r_view;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tuser  = r_out_view;

`ifndef ASSERT_OFF
    a_no_transfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfpt_pkg::ST_CLEAR) |-> !o_s_axis_tready)
        else $error("input transfer during clearing sweep");

    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfpt_pkg::ST_READ && w_out_free) |=> o_m_axis_tvalid)
        else $error("pending read not loaded into output register");

    a_modify_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mfpt_pkg::ST_MODIFY) |-> $past(w_re))
        else $error("capture write-back without bank read");

    a_cap_page_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cap_page) <= mfpt_pkg::PAGE_COUNT)
        else $error("capture page advanced past end of image");
`endif

endmodule

/* tb/monochrome_frame_page_transposer_tb.sv */
module monochrome_frame_page_transposer_tb;

    import mfpt_pkg::*;

    localparam int KIND_LAST   = (1 << KIND_W) - 1;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 16;
    localparam int PAGE_BYTES  = ROW_BYTES * ROWS_PER_PAGE;

    localparam logic VIEW_ROW    = 1'b0;
    localparam logic VIEW_COLUMN = 1'b1;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_EVERY_FOURTH,
        RX_SPARSE
    } rx_mode_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] row_address;
        logic [PAGE_W-1:0] page_number;
        logic [COL_W-1:0]  column_index;
        logic [BYTE_W-1:0] data_byte;
        bit                drain_first;
    } frame_item_t;

    typedef struct {
        logic [BYTE_W-1:0] read_byte;
        logic              read_view;
    } read_result_t;

    logic                  clk;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    frame_item_t           pending_items[$];
    read_result_t          pending_reads[$];

    logic [BYTE_W-1:0]     frame_bytes [MEM_BYTES];
    logic [CAP_PAGE_W-1:0] cap_page = '0;
    logic [COL_W-1:0]      cap_col  = '0;

    int                    error_count = 0;
    int                    cycle_count = 0;
    int                    burst_left  = 1;
    int                    gap_left    = 0;
    rx_mode_t              rx_mode     = RX_OPEN;
    int                    rx_left     = 0;
    int                    rx_phase    = 0;

    monochrome_frame_page_transposer u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycle_count, what, got, want);
        error_count++;
    endtask

    function automatic logic cell_in_image(input int page, input int col);
        return page < PAGE_COUNT && col < PIXEL_WIDTH && (col / 8) < ROW_BYTES;
    endfunction

    function automatic logic [BYTE_W-1:0] gather_column(input int page, input int col);
        int                base;
        logic [BYTE_W-1:0] mask;
        logic [BYTE_W-1:0] v;
        base = page * PAGE_BYTES + col / 8;
        mask = 8'h80 >> (col % 8);
        v = '0;
        for (int k = 0; k < ROWS_PER_PAGE; k++)
            v[k] = |(frame_bytes[base + k * ROW_BYTES] & mask);
        return v;
    endfunction

    function automatic void scatter_column(input int page, input int col,
                                           input logic [BYTE_W-1:0] v);
        int                base;
        logic [BYTE_W-1:0] mask;
        base = page * PAGE_BYTES + col / 8;
        mask = 8'h80 >> (col % 8);
        for (int k = 0; k < ROWS_PER_PAGE; k++) begin
            if (v[k])
                frame_bytes[base + k * ROW_BYTES] |= mask;
            else
                frame_bytes[base + k * ROW_BYTES] &= ~mask;
        end
    endfunction

    // advance the frame image by one transfer and note any read it returns
    function automatic void update_frame_image(input frame_item_t it);
        read_result_t r;
        int           next_col;
        case (it.kind)
            KIND_ROW_WR: begin
                if (int'(it.row_address) < MEM_BYTES)
                    frame_bytes[it.row_address] = it.data_byte;
            end
            KIND_ROW_RD: begin
                r.read_byte = (int'(it.row_address) < MEM_BYTES) ?
                              frame_bytes[it.row_address] : '0;
                r.read_view = VIEW_ROW;
                pending_reads.push_back(r);
            end
            KIND_SEL_PAGE: begin
                cap_page = CAP_PAGE_W'(it.page_number);
                cap_col  = '0;
            end
            KIND_CAP_WR: begin
                if (cell_in_image(int'(cap_page), int'(cap_col))) begin
                    scatter_column(int'(cap_page), int'(cap_col), it.data_byte);
                    next_col = int'(cap_col) + 1;
                    if (next_col >= PIXEL_WIDTH) begin
                        cap_col  = '0;
                        cap_page = cap_page + 1'b1;
                    end else begin
                        cap_col = COL_W'(next_col);
                    end
                end
            end
            KIND_COL_RD: begin
                r.read_byte = cell_in_image(int'(it.page_number), int'(it.column_index)) ?
                              gather_column(int'(it.page_number), int'(it.column_index)) : '0;
                r.read_view = VIEW_COLUMN;
                pending_reads.push_back(r);
            end
            default: begin
            end
        endcase
    endfunction

    task automatic queue_item(input int kind, input int addr, input int page,
                              input int col, input int data);
        frame_item_t it;
        it.kind         = KIND_W'(kind);
        it.row_address  = ADDR_W'(addr);
        it.page_number  = PAGE_W'(page);
        it.column_index = COL_W'(col);
        it.data_byte    = BYTE_W'(data);
        it.drain_first  = 1'b0;
        pending_items.push_back(it);
    endtask

    // sender: bursts of transfers separated by random gaps
    always @(posedge clk) begin : driver
        bit fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (fire) begin
                update_frame_image(pending_items.pop_front());
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
            if (!s_axis_tvalid || fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items[0].drain_first && pending_reads.size() != 0) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tdata  <= S_TDATA_W'({pending_items[0].data_byte,
                                                 pending_items[0].column_index,
                                                 pending_items[0].page_number,
                                                 pending_items[0].row_address});
                    s_axis_tuser  <= pending_items[0].kind;
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver stalls on its own pattern
    always @(posedge clk) begin : receiver
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN:         m_axis_tready <= 1'b1;
                RX_COIN:         m_axis_tready <= ($urandom_range(0, 1) == 0);
                RX_EVERY_FOURTH: m_axis_tready <= (rx_phase % 4 != 0);
                default:         m_axis_tready <= (rx_phase % 7 < 2);
            endcase
        end
    end

    always @(posedge clk) begin : monitor
        read_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                report_mismatch("unexpected transfer, read_byte", m_axis_tdata, 0);
            end else begin
                want = pending_reads.pop_front();
                if (m_axis_tdata !== want.read_byte)
                    report_mismatch("read_byte", m_axis_tdata, want.read_byte);
                if (m_axis_tuser !== want.read_view)
                    report_mismatch("read_view", m_axis_tuser, want.read_view);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int random_count;
        int seg;
        int n;
        int p;
        int base;
        int addr;
        int pick;
        int top;

        foreach (frame_bytes[i])
            frame_bytes[i] = '0;

        // reads of the cleared store at the corners
        queue_item(KIND_ROW_RD, 0, $urandom, $urandom, $urandom);
        queue_item(KIND_ROW_RD, MEM_BYTES - 1, $urandom, $urandom, $urandom);
        queue_item(KIND_COL_RD, $urandom, PAGE_COUNT - 1, PIXEL_WIDTH - 1, $urandom);
        // corner pixels seen through both views
        queue_item(KIND_ROW_WR, 0, $urandom, $urandom, 8'h80);
        queue_item(KIND_ROW_WR, MEM_BYTES - 1, $urandom, $urandom, 8'h01);
        queue_item(KIND_COL_RD, $urandom, 0, 0, $urandom);
        queue_item(KIND_COL_RD, $urandom, PAGE_COUNT - 1, PIXEL_WIDTH - 1, $urandom);
        queue_item(KIND_ROW_RD, 0, $urandom, $urandom, $urandom);
        queue_item(KIND_ROW_RD, MEM_BYTES - 1, $urandom, $urandom, $urandom);
        // capture into the last page, then read back both ways
        queue_item(KIND_SEL_PAGE, $urandom, PAGE_COUNT - 1, $urandom, $urandom);
        queue_item(KIND_CAP_WR, $urandom, $urandom, $urandom, 8'hA5);
        queue_item(KIND_CAP_WR, $urandom, $urandom, $urandom, 8'hFF);
        queue_item(KIND_CAP_WR, $urandom, $urandom, $urandom, 8'h00);
        queue_item(KIND_COL_RD, $urandom, PAGE_COUNT - 1, 0, $urandom);
        queue_item(KIND_COL_RD, $urandom, PAGE_COUNT - 1, 1, $urandom);
        queue_item(KIND_COL_RD, $urandom, PAGE_COUNT - 1, 2, $urandom);
        queue_item(KIND_ROW_RD, (PAGE_COUNT - 1) * PAGE_BYTES, $urandom, $urandom, $urandom);
        // unused kinds do nothing
        for (int k = int'(KIND_COL_RD) + 1; k <= KIND_LAST; k++)
            queue_item(k, $urandom, $urandom, $urandom, $urandom);
        // capture over an existing row-written pixel
        queue_item(KIND_SEL_PAGE, $urandom, 0, $urandom, $urandom);
        queue_item(KIND_CAP_WR, $urandom, $urandom, $urandom, 8'h5A);
        queue_item(KIND_COL_RD, $urandom, 0, 0, $urandom);
        queue_item(KIND_ROW_RD, 0, $urandom, $urandom, $urandom);

        // run the capture position off the end of the image
        queue_item(KIND_SEL_PAGE, $urandom, PAGE_COUNT - 1, $urandom, $urandom);
        pending_items[pending_items.size() - 1].drain_first = 1'b1;
        for (int k = 0; k < PIXEL_WIDTH + 4; k++)
            queue_item(KIND_CAP_WR, $urandom, $urandom, $urandom, $urandom);
        queue_item(KIND_COL_RD, $urandom, PAGE_COUNT - 1, PIXEL_WIDTH - 1, $urandom);
        queue_item(KIND_COL_RD, $urandom, 0, 1, $urandom);
        random_count = PIXEL_WIDTH + 7;

        while (random_count < RANDOM_ITEMS) begin
            seg = $urandom_range(0, 9);
            if (seg < 4) begin
                p = $urandom_range(0, PAGE_COUNT - 1);
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 24);
                queue_item(KIND_SEL_PAGE, $urandom, p, $urandom, $urandom);
                for (int k = 0; k < n; k++)
                    queue_item(KIND_CAP_WR, $urandom, $urandom, $urandom, $urandom);
                top = (n > PIXEL_WIDTH) ? PIXEL_WIDTH - 1 : n - 1;
                for (int k = $urandom_range(1, 6); k > 0; k--) begin
                    queue_item(KIND_COL_RD, $urandom,
                               (n > PIXEL_WIDTH && $urandom_range(0, 1)) ? (p + 1) % PAGE_COUNT : p,
                               $urandom_range(0, top), $urandom);
                    random_count++;
                end
                queue_item(KIND_ROW_RD, p * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1),
                           $urandom, $urandom, $urandom);
                random_count += n + 2;
            end else if (seg < 7) begin
                base = $urandom_range(0, MEM_BYTES - 1);
                n = $urandom_range(2, 12);
                for (int k = 0; k < n; k++) begin
                    addr = (base + $urandom_range(0, 47)) % MEM_BYTES;
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        queue_item(KIND_ROW_WR, addr, $urandom, $urandom, $urandom);
                    else if (pick == 1)
                        queue_item(KIND_ROW_RD, addr, $urandom, $urandom, $urandom);
                    else
                        queue_item(KIND_COL_RD, $urandom, addr / PAGE_BYTES,
                                   (addr % ROW_BYTES) * 8 + $urandom_range(0, 7), $urandom);
                end
                random_count += n;
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++) begin
                    pick = $urandom_range(0, KIND_LAST);
                    queue_item(pick, $urandom, $urandom, $urandom, $urandom);
                    if (pick <= int'(KIND_COL_RD))
                        random_count++;
                end
            end
            if ($urandom_range(0, 39) == 0)
                pending_items[pending_items.size() - 1].drain_first = 1'b1;
        end

        @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
